[rtl/core/fir_pkg.sv]
// ----------------------------------------------------------------------------
// fir_pkg
// Types, constants and coefficient selection shared by the FIR filter.
// ----------------------------------------------------------------------------
package fir_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;
    localparam int TAPSCFG_W = 4;
    localparam int DIV_W     = 15;
    localparam int NUM_COEFS = 8;
    localparam int TAP_IDX_W = 7;   // holds any tap count up to 64

    localparam logic [CFG_IDX_W-1:0] REG_COEFFS_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFFS_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS_IN_USE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_DIV   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DIV,
        ST_OUT
    } t_state;

    function automatic logic [COEF_W-1:0] coef_sel(
        input logic [CFG_W-1:0] lo,
        input logic [CFG_W-1:0] hi,
        input logic [2:0]       idx
    );
        logic [CFG_W-1:0] word;
        word = idx[2] ? hi : lo;
        return word[idx[1:0]*COEF_W +: COEF_W];
    endfunction

endpackage

[rtl/core/fir_filter_int16.sv]
// ----------------------------------------------------------------------------
// fir_filter_int16
// Direct-form FIR filter on signed 16-bit samples with integer scaling.
//
//   channel   direction  handshake                 payload
//   in        sink       i_in_valid / o_in_stall   i_sample, i_clear_history
//   out       source     o_out_valid / i_out_stall o_filtered
//   cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Each sample is multiply-accumulated over the n taps in use on one shared
// 16x16 multiplier, divided in the bit-serial divider and loaded into the
// output register; the next sample is taken once the sequencer is idle.
// Reset is synchronous, active low; history reads as zero until written.
// A result held under output stall holds the sequencer before the next load.
// ----------------------------------------------------------------------------
module fir_filter_int16 #(
    parameter int TAPS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [fir_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_clear_history,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [fir_pkg::SAMPLE_W-1:0] o_filtered,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fir_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fir_pkg::CFG_W-1:0]     i_cfg_data
);
    import fir_pkg::*;

    localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CNT_W = $clog2(TAPS + 1);
    localparam int ACC_W = 33 + $clog2(TAPS);

    // configuration
    logic [CFG_W-1:0]     r_coeffs_low;
    logic [CFG_W-1:0]     r_coeffs_high;
    logic [TAPSCFG_W-1:0] r_taps;
    logic [DIV_W-1:0]     r_scale;

    // history ring
    logic [SAMPLE_W-1:0]  r_mem [TAPS];
    logic [TAPS-1:0]      r_hvalid;
    logic [AW-1:0]        r_wpos;

    // sequencer and datapath
    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_issue_cnt;
    logic [CNT_W-1:0]     r_n;
    logic [AW-1:0]        r_pos;
    logic                 r_d1, r_d2;
    logic [SAMPLE_W-1:0]  r_rdata;
    logic                 r_rvalid;
    logic signed [COEF_W-1:0] r_c1;
    logic signed [31:0]   r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic                 r_neg;
    logic                 r_out_valid;
    logic signed [SAMPLE_W-1:0] r_filtered;

    logic                 in_acc;
    logic                 issuing;
    logic                 mac_done;
    logic                 div_start;
    logic                 load_out;
    logic [AW-1:0]        wslot;
    logic [CNT_W-1:0]     n_taps;
    logic [TAP_IDX_W-1:0] tap_wide;
    logic [COEF_W-1:0]    coef;
    logic [7:0]           pos_w, idx_w, slot_w;
    logic [AW-1:0]        rd_addr;
    logic signed [SAMPLE_W-1:0] hist;
    logic [ACC_W-1:0]     mag;
    logic [DIV_W-1:0]     div_eff;
    logic                 div_done;
    logic [ACC_W-1:0]     quotient;
    logic [SAMPLE_W-1:0]  q16;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;

    assign wslot  = i_clear_history ? '0 : r_wpos;
    assign n_taps = (TAP_IDX_W'(r_taps) > TAP_IDX_W'(TAPS)) ? CNT_W'(TAPS) : CNT_W'(r_taps);

    assign issuing  = (r_state == ST_MAC) && (r_issue_cnt < r_n);
    assign mac_done = !issuing && !r_d1 && !r_d2;

    assign tap_wide = TAP_IDX_W'(r_issue_cnt);
    assign coef     = (tap_wide < TAP_IDX_W'(NUM_COEFS))
                    ? coef_sel(r_coeffs_low, r_coeffs_high, tap_wide[2:0]) : '0;

    assign pos_w   = 8'(r_pos);
    assign idx_w   = 8'(r_issue_cnt);
    assign slot_w  = (pos_w >= idx_w) ? pos_w - idx_w : pos_w + 8'(TAPS) - idx_w;
    assign rd_addr = AW'(slot_w);

    assign hist    = r_rvalid ? $signed(r_rdata) : '0;
    assign mag     = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign div_eff = (r_scale == '0) ? DIV_W'(1) : r_scale;
    assign q16     = quotient[SAMPLE_W-1:0];

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) n_state = ST_MAC;
            end
            ST_MAC: begin
                if (mac_done) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeffs_low  <= '0;
            r_coeffs_high <= '0;
            r_taps        <= TAPSCFG_W'(8);
            r_scale       <= DIV_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_COEFFS_LOW:  r_coeffs_low  <= i_cfg_data;
                REG_COEFFS_HIGH: r_coeffs_high <= i_cfg_data;
                REG_TAPS_IN_USE: r_taps        <= i_cfg_data[TAPSCFG_W-1:0];
                REG_SCALE_DIV:   r_scale       <= i_cfg_data[DIV_W-1:0];
                default: ;
            endcase
        end
    end

    // history valid bits and write pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvalid <= '0;
            r_wpos   <= '0;
        end else if (in_acc) begin
            if (i_clear_history) begin
                r_hvalid <= TAPS'(1);
            end else begin
                r_hvalid[wslot] <= 1'b1;
            end
            r_wpos <= (wslot == AW'(TAPS - 1)) ? '0 : wslot + 1'b1;
        end
    end

    // history memory, registered read
    always_ff @(posedge i_clk) begin
        if (in_acc) r_mem[wslot] <= i_sample;
        r_rdata  <= r_mem[rd_addr];
        r_rvalid <= r_hvalid[rd_addr];
    end

    // MAC pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= 1'b0;
            r_d2 <= 1'b0;
        end else begin
            r_d1 <= issuing;
            r_d2 <= r_d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_issue_cnt <= '0;
            r_n         <= n_taps;
            r_pos       <= wslot;
            r_acc       <= '0;
        end else begin
            if (issuing) r_issue_cnt <= r_issue_cnt + 1'b1;
            if (r_d2)    r_acc <= r_acc + ACC_W'(r_prod);
        end
        r_c1   <= $signed(coef);
        r_prod <= r_c1 * hist;
        if (div_start) r_neg <= r_acc[ACC_W-1];
    end

    fir_divider #(
        .DIVIDEND_W (ACC_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mag),
        .i_divisor  (div_eff),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) r_filtered <= $signed(r_neg ? -q16 : q16);
    end

    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_filtered;

endmodule

[rtl/core/fir_divider.sv]
// ----------------------------------------------------------------------------
// fir_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fir_divider #(
    parameter int DIVIDEND_W = 36
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DIVIDEND_W-1:0]    i_dividend,
    input  logic [fir_pkg::DIV_W-1:0] i_divisor,
    output logic                     o_done,
    output logic [DIVIDEND_W-1:0]    o_quotient
);
    import fir_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIV_W-1:0]      r_rem;
    logic [DIVIDEND_W-1:0] r_quo;

    logic [DIV_W:0]        shifted;
    logic [DIV_W+1:0]      trial;
    logic                  qbit;
    logic [DIV_W-1:0]      n_rem;

    always_comb begin
        shifted = {r_rem, r_quo[DIVIDEND_W-1]};
        trial   = {1'b0, shifted} - {2'b00, i_divisor};
        qbit    = !trial[DIV_W+1];
        n_rem   = qbit ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIVIDEND_W-2:0], qbit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 16-bit direct-form FIR filter. A short directed
// table covers sample extremes, wrap-around, history clears, zero and excess
// tap counts, zero and maximum divisors and truncation toward zero. Random
// samples under random register settings follow. Every output transaction is
// compared with its typed plan value or else a local model of the filter,
// under three sender and receiver idling profiles.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fir_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int RAND_PHASES    = 7;
    localparam int PHASE_SAMPLES  = 100;
    localparam int DRAIN_CYCLES   = 60;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
    } reg_wr_t;

    typedef struct {
        bit                          is_cfg;
        logic [CFG_IDX_W-1:0]        idx;
        logic [CFG_W-1:0]            data;
        logic signed [SAMPLE_W-1:0]  smp;
        bit                          clr;
        bit                          typed;
        logic signed [SAMPLE_W-1:0]  want;
    } plan_row_t;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         in_valid;
    logic                         o_in_stall;
    logic signed [SAMPLE_W-1:0]   in_sample;
    logic                         in_clear;
    logic                         o_out_valid;
    logic                         out_stall;
    logic signed [SAMPLE_W-1:0]   o_filtered;
    logic                         cfg_valid;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_W-1:0]             cfg_data;

    // filter model state
    logic [CFG_W-1:0]             coef_lo;
    logic [CFG_W-1:0]             coef_hi;
    logic [TAPSCFG_W-1:0]         cur_taps;
    logic [DIV_W-1:0]             cur_div;
    logic signed [SAMPLE_W-1:0]   hist [NUM_COEFS];
    logic [2:0]                   wr_pos;

    logic signed [SAMPLE_W-1:0]   filtered_q [$];
    int                           n_mismatch;
    int                           n_cycles = 0;
    int                           n_sent;
    int                           snd_idle_pct;
    int                           rcv_idle_pct;

    fir_filter_int16 i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_sample        (in_sample),
        .i_clear_history (in_clear),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_filtered      (o_filtered),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // directed plan: register writes and samples, typed results where obvious
    plan_row_t plan [] = '{
        '{0, REG_COEFFS_LOW, 64'h0, 16'sd100, 0, 1, 16'sd0},
        '{0, REG_COEFFS_LOW, 64'h0, 16'sh8000, 0, 1, 16'sd0},
        '{1, REG_COEFFS_LOW, 64'h0000_0000_0000_0001, 16'sd0, 0, 0, 16'sd0},
        '{1, REG_TAPS_IN_USE, 64'd1, 16'sd0, 0, 0, 16'sd0},
        '{0, REG_COEFFS_LOW, 64'h0, 16'sh7fff, 0, 1, 16'sh7fff},
        '{0, REG_COEFFS_LOW, 64'h0, 16'sh8000, 0, 1, 16'sh8000},
        '{0, REG_COEFFS_LOW, 64'h0, 16'sd0, 0, 1, 16'sd0},
        '{1, REG_COEFFS_LOW, 64'hffff_ffff_ffff_ffff, 16'sd0, 0, 0, 16'sd0},
        '{1, REG_COEFFS_HIGH, 64'hffff_ffff_ffff_ffff, 16'sd0, 0, 0, 16'sd0},
        '{1, REG_TAPS_IN_USE, 64'd8, 16'sd0, 0, 0, 16'sd0},
        '{0, REG_COEFFS_LOW, 64'h0, 16'sh8000, 1, 1, 16'sh8000},
        '{0, REG_COEFFS_LOW, 64'h0, 16'sh8000, 0, 1, 16'sd0},
        '{1, REG_TAPS_IN_USE, 64'd0, 16'sd0, 0, 0, 16'sd0},
        '{0, REG_COEFFS_LOW, 64'h0, 16'sd1234, 0, 1, 16'sd0},
        '{1, REG_COEFFS_LOW, 64'h7fff_7fff_7fff_7fff, 16'sd0, 0, 0, 16'sd0},
        '{1, REG_COEFFS_HIGH, 64'h7fff_7fff_7fff_7fff, 16'sd0, 0, 0, 16'sd0},
        '{1, REG_TAPS_IN_USE, 64'd15, 16'sd0, 0, 0, 16'sd0},
        '{0, REG_COEFFS_LOW, 64'h0, 16'sh7fff, 0, 0, 16'sd0},
        '{0, REG_COEFFS_LOW, 64'h0, 16'sh8000, 0, 0, 16'sd0},
        '{0, REG_COEFFS_LOW, 64'h0, -16'sd1, 0, 0, 16'sd0},
        '{0, REG_COEFFS_LOW, 64'h0, 16'sd1, 1, 0, 16'sd0},
        '{1, REG_COEFFS_LOW, 64'h8000_8000_8000_8000, 16'sd0, 0, 0, 16'sd0},
        '{1, REG_COEFFS_HIGH, 64'h8000_8000_8000_8000, 16'sd0, 0, 0, 16'sd0},
        '{1, REG_SCALE_DIV, 64'd0, 16'sd0, 0, 0, 16'sd0},
        '{0, REG_COEFFS_LOW, 64'h0, 16'sh8000, 1, 1, 16'sd0},
        '{0, REG_COEFFS_LOW, 64'h0, 16'sh8000, 0, 0, 16'sd0},
        '{0, REG_COEFFS_LOW, 64'h0, 16'sh7fff, 0, 0, 16'sd0},
        '{1, REG_SCALE_DIV, 64'd32767, 16'sd0, 0, 0, 16'sd0},
        '{1, REG_COEFFS_LOW, 64'h7fff_7fff_7fff_7fff, 16'sd0, 0, 0, 16'sd0},
        '{0, REG_COEFFS_LOW, 64'h0, 16'sh7fff, 0, 0, 16'sd0},
        '{0, REG_COEFFS_LOW, 64'h0, 16'sh8000, 0, 0, 16'sd0},
        '{0, REG_COEFFS_LOW, 64'h0, 16'sh5555, 0, 0, 16'sd0},
        '{1, REG_COEFFS_LOW, 64'h0000_0000_0000_0001, 16'sd0, 0, 0, 16'sd0},
        '{1, REG_TAPS_IN_USE, 64'd1, 16'sd0, 0, 0, 16'sd0},
        '{1, REG_SCALE_DIV, 64'd3, 16'sd0, 0, 0, 16'sd0},
        '{0, REG_COEFFS_LOW, 64'h0, -16'sd7, 0, 1, -16'sd2},
        '{0, REG_COEFFS_LOW, 64'h0, 16'sd7, 0, 1, 16'sd2},
        '{0, REG_COEFFS_LOW, 64'h0, 16'sd5, 1, 1, 16'sd1}
    };

    function automatic logic signed [SAMPLE_W-1:0] fir_predict(
        input logic signed [SAMPLE_W-1:0] smp,
        input logic                       clr
    );
        longint           acc;
        longint           quo;
        int               n;
        int unsigned      d;
        logic [2:0]       pos;
        logic [2:0]       slot;
        logic [CFG_W-1:0] word;
        logic [COEF_W-1:0] cw;
        if (clr) begin
            foreach (hist[k]) hist[k] = '0;
            wr_pos = '0;
        end
        pos = wr_pos;
        hist[pos] = smp;
        wr_pos = pos + 3'd1;
        n = (cur_taps > NUM_COEFS) ? NUM_COEFS : int'(cur_taps);
        acc = 0;
        for (int i = 0; i < n; i++) begin
            slot = pos - 3'(i);
            word = (i < 4) ? coef_lo : coef_hi;
            cw = word[(i % 4) * COEF_W +: COEF_W];
            acc += longint'($signed(cw)) * longint'(hist[slot]);
        end
        d = (cur_div == 0) ? 1 : cur_div;
        quo = acc / longint'(d);
        return quo[SAMPLE_W-1:0];
    endfunction

    task automatic apply_reg(input reg_wr_t w);
        case (w.idx)
            REG_COEFFS_LOW:  coef_lo = w.data;
            REG_COEFFS_HIGH: coef_hi = w.data;
            REG_TAPS_IN_USE: cur_taps = w.data[TAPSCFG_W-1:0];
            REG_SCALE_DIV:   cur_div = w.data[DIV_W-1:0];
            default: ;
        endcase
    endtask

    // only once the filter has drained; valid stays high across a batch
    task automatic write_regs(input reg_wr_t ws [$]);
        in_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        foreach (ws[k]) begin
            cfg_valid <= 1'b1;
            cfg_index <= ws[k].idx;
            cfg_data  <= ws[k].data;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            apply_reg(ws[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(
        input logic signed [SAMPLE_W-1:0] smp,
        input logic                       clr,
        input bit                         typed,
        input logic signed [SAMPLE_W-1:0] want
    );
        logic signed [SAMPLE_W-1:0] pred;
        if (n_sent < 240) begin
            snd_idle_pct = 15;
            rcv_idle_pct = 76;
        end else if (n_sent < 480) begin
            snd_idle_pct = 76;
            rcv_idle_pct = 15;
        end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
        end
        if ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < snd_idle_pct) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        in_sample <= smp;
        in_clear  <= clr;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = fir_predict(smp, clr);
        filtered_q.push_back(typed ? want : pred);
        n_sent++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sd0;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_coefs();
        case ($urandom_range(5))
            0: return 64'h7fff_7fff_7fff_7fff;
            1: return 64'h8000_8000_8000_8000;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // output side: check each transaction, then choose next cycle's stall
    initial begin
        out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !out_stall) begin
                if (filtered_q.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display("unexpected output transaction: %0d", o_filtered);
                end else begin
                    logic signed [SAMPLE_W-1:0] exp_val;
                    exp_val = filtered_q.pop_front();
                    if (o_filtered !== exp_val) begin
                        n_mismatch++;
                        if (n_mismatch <= MAX_REPORTS)
                            $display("filtered mismatch: expected %0d, got %0d",
                                     exp_val, o_filtered);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    initial begin
        reg_wr_t   pending [$];
        reg_wr_t   w;
        int        dsel;
        in_valid   = 1'b0;
        in_sample  = '0;
        in_clear   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_COEFFS_LOW;
        cfg_data   = '0;
        i_rst_n    = 1'b0;
        n_mismatch = 0;
        n_sent     = 0;
        snd_idle_pct = 15;
        rcv_idle_pct = 76;
        coef_lo  = '0;
        coef_hi  = '0;
        cur_taps = TAPSCFG_W'(8);
        cur_div  = DIV_W'(1);
        wr_pos   = '0;
        foreach (hist[k]) hist[k] = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].is_cfg) begin
                w.idx  = plan[r].idx;
                w.data = plan[r].data;
                pending.push_back(w);
                if (r == plan.size() - 1 || !plan[r+1].is_cfg) begin
                    write_regs(pending);
                    pending.delete();
                end
            end else begin
                send_sample(plan[r].smp, plan[r].clr, plan[r].typed, plan[r].want);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            pending.delete();
            w.idx = REG_COEFFS_LOW;
            w.data = rand_coefs();
            pending.push_back(w);
            w.idx = REG_COEFFS_HIGH;
            w.data = rand_coefs();
            pending.push_back(w);
            w.idx = REG_TAPS_IN_USE;
            w.data = ($urandom_range(3) == 0) ? CFG_W'($urandom_range(15))
                                              : CFG_W'($urandom_range(1, 8));
            pending.push_back(w);
            w.idx = REG_SCALE_DIV;
            dsel = $urandom_range(5);
            case (dsel)
                0: w.data = CFG_W'(0);
                1: w.data = CFG_W'(1);
                2: w.data = CFG_W'(32767);
                3: w.data = CFG_W'($urandom_range(2, 15));
                default: w.data = CFG_W'($urandom_range(1, 32767));
            endcase
            pending.push_back(w);
            write_regs(pending);
            for (int k = 0; k < PHASE_SAMPLES; k++)
                send_sample(rand_sample(), ($urandom_range(19) == 0), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0 && filtered_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
